// ===== rtl/rpo_pkg.sv =====
// Package for the RGB pixel point operation block.
// Holds the payload and control types, register codes and shared constants.
// No dependencies.
package rpo_pkg;

  localparam int MAX_EXPONENT_DEF = 8;

  localparam int PIX_W    = 8;
  localparam int NUM_CH   = 3;
  localparam int CURVE_AW = PIX_W;
  localparam int CURVE_DEPTH = 1 << CURVE_AW;

  localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};

  localparam int CFG_AW = 3;
  localparam int APB_DW = 32;
  localparam int GAMMA_W = 4;
  localparam logic [GAMMA_W-1:0] GAMMA_RESET = 4'd2;
  localparam logic [GAMMA_W-1:0] GAMMA_MIN   = 4'd2;

  localparam int GREY_SUM_W  = PIX_W + 2;
  localparam int GREY_PROD_W = 2 * GREY_SUM_W;
  localparam int GREY_RECIP  = 683;
  localparam int GREY_SHIFT  = 11;

  localparam logic REG_OP_MODE = 1'b0;
  localparam logic REG_GAMMA   = 1'b1;

  typedef enum logic [1:0] {
    MODE_GREY    = 2'd0,
    MODE_INVERT  = 2'd1,
    MODE_DARKEN  = 2'd2,
    MODE_LIGHTEN = 2'd3
  } op_mode_t;

  typedef enum logic [1:0] {
    GEN_IDLE,
    GEN_KPOW,
    GEN_POW,
    GEN_CMP
  } gen_state_t;

  typedef struct packed {
    logic [PIX_W-1:0] in_red;
    logic [PIX_W-1:0] in_green;
    logic [PIX_W-1:0] in_blue;
  } pixel_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_red;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_blue;
  } pixel_out_t;

  typedef struct packed {
    op_mode_t op_mode;
    logic     restart;
  } cfg_t;

  typedef struct packed {
    logic                we;
    logic [CURVE_AW-1:0] addr;
    logic [PIX_W-1:0]    data;
  } curve_wr_t;

endpackage

// ===== rtl/rpo_cfg_regs.sv =====
// Configuration registers behind the APB-style port.
// Holds the operation mode and the gamma exponent, and flags a curve rebuild.
// Depends on rpo_pkg.
module rpo_cfg_regs #(
  parameter int MAX_EXPONENT = rpo_pkg::MAX_EXPONENT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rpo_pkg::CFG_AW-1:0]          paddr,
  input  logic [rpo_pkg::APB_DW-1:0]          pwdata,
  output logic [rpo_pkg::APB_DW-1:0]          prdata,
  output logic                                pready,
  output rpo_pkg::cfg_t                       cfg,
  output logic [$clog2(MAX_EXPONENT+1)-1:0]   exp_n
);
  import rpo_pkg::*;

  localparam int NW = $clog2(MAX_EXPONENT + 1);

  op_mode_t           op_mode_r;
  logic [GAMMA_W-1:0] gamma_r;
  logic               restart_r;
  logic               wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_mode_r <= MODE_GREY;
      gamma_r   <= GAMMA_RESET;
      restart_r <= 1'b0;
    end else begin
      restart_r <= wr_en;
      if (wr_en) begin
        case (paddr[2])
          REG_OP_MODE: op_mode_r <= op_mode_t'(pwdata[1:0]);
          REG_GAMMA:   gamma_r   <= pwdata[GAMMA_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    if (gamma_r < GAMMA_MIN) begin
      exp_n = NW'(GAMMA_MIN);
    end else if (32'(gamma_r) > MAX_EXPONENT) begin
      exp_n = NW'(MAX_EXPONENT);
    end else begin
      exp_n = NW'(gamma_r);
    end
  end

  always_comb begin
    case (paddr[2])
      REG_OP_MODE: prdata = APB_DW'(op_mode_r);
      default:     prdata = APB_DW'(gamma_r);
    endcase
  end

  assign cfg.op_mode = op_mode_r;
  assign cfg.restart = restart_r;

endmodule

// ===== rtl/rpo_curve_gen.sv =====
// Sequencer that rebuilds the gamma curve table after reset and each register write.
// Exact integer search with one wide multiply-by-byte and one wide add and compare.
// Depends on rpo_pkg.
module rpo_curve_gen #(
  parameter int MAX_EXPONENT = rpo_pkg::MAX_EXPONENT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rpo_pkg::cfg_t                       cfg,
  input  logic [$clog2(MAX_EXPONENT+1)-1:0]   exp_n,
  output rpo_pkg::curve_wr_t                  wr,
  output logic                                busy
);
  import rpo_pkg::*;

  localparam int NW = $clog2(MAX_EXPONENT + 1);
  localparam int BW = PIX_W * MAX_EXPONENT + PIX_W;

  gen_state_t state_r, state_nxt;

  logic [BW-1:0]       k_r,   k_nxt;
  logic [BW-1:0]       acc_r, acc_nxt;
  logic [BW-1:0]       pw_r,  pw_nxt;
  logic [NW-1:0]       cnt_r, cnt_nxt;
  logic [CURVE_AW-1:0] x_r,   x_nxt;
  logic [PIX_W-1:0]    y_r,   y_nxt;

  logic             lighten;
  logic [PIX_W-1:0] mul_base;
  logic [BW-1:0]    prod;
  logic             k_last;
  logic             p_last;
  logic             hit;
  logic             x_last;

  assign lighten = (cfg.op_mode == MODE_LIGHTEN);
  assign k_last  = (cnt_r == exp_n - NW'(2));
  assign p_last  = (cnt_r == exp_n - NW'(1));
  assign x_last  = (x_r == PIX_MAX);

  always_comb begin
    case (state_r)
      GEN_KPOW: mul_base = PIX_MAX;
      default:  mul_base = lighten ? (y_r + PIX_W'(1)) : x_r;
    endcase
  end

  assign prod = pw_r * BW'(mul_base);

  always_comb begin
    if (lighten) begin
      hit = (y_r != PIX_MAX) && (pw_r <= acc_r);
    end else begin
      hit = (acc_r <= pw_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    if (cfg.restart) begin
      state_nxt = GEN_KPOW;
    end else begin
      case (state_r)
        GEN_IDLE: state_nxt = GEN_IDLE;
        GEN_KPOW: if (k_last) state_nxt = GEN_POW;
        GEN_POW:  if (p_last) state_nxt = GEN_CMP;
        GEN_CMP: begin
          if (hit) begin
            state_nxt = lighten ? GEN_POW : GEN_CMP;
          end else if (x_last) begin
            state_nxt = GEN_IDLE;
          end else begin
            state_nxt = lighten ? GEN_CMP : GEN_POW;
          end
        end
        default: state_nxt = GEN_IDLE;
      endcase
    end
  end

  always_comb begin
    busy    = (state_r != GEN_IDLE) || cfg.restart;
    wr.we   = (state_r == GEN_CMP) && !hit && !cfg.restart;
    wr.addr = x_r;
    wr.data = y_r;
  end

  always_comb begin
    k_nxt   = k_r;
    acc_nxt = acc_r;
    pw_nxt  = pw_r;
    cnt_nxt = cnt_r;
    x_nxt   = x_r;
    y_nxt   = y_r;
    if (cfg.restart) begin
      pw_nxt  = BW'(1);
      cnt_nxt = '0;
    end else begin
      case (state_r)
        GEN_KPOW: begin
          pw_nxt  = prod;
          cnt_nxt = cnt_r + NW'(1);
          if (k_last) begin
            k_nxt   = prod;
            acc_nxt = lighten ? '0 : prod;
            x_nxt   = '0;
            y_nxt   = '0;
            pw_nxt  = BW'(1);
            cnt_nxt = '0;
          end
        end
        GEN_POW: begin
          pw_nxt  = prod;
          cnt_nxt = p_last ? '0 : cnt_r + NW'(1);
        end
        GEN_CMP: begin
          if (hit) begin
            y_nxt = y_r + PIX_W'(1);
            if (lighten) begin
              pw_nxt = BW'(1);
            end else begin
              acc_nxt = acc_r + k_r;
            end
          end else begin
            x_nxt = x_r + CURVE_AW'(1);
            if (lighten) begin
              acc_nxt = acc_r + k_r;
            end else begin
              pw_nxt = BW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= GEN_KPOW;
      pw_r    <= BW'(1);
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pw_r    <= pw_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r   <= k_nxt;
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
  end

endmodule

// ===== rtl/rpo_curve_ram.sv =====
// Curve table memory, one bank per color channel, all written together.
// Each bank has one write port and one registered read port.
// Depends on rpo_pkg.
module rpo_curve_ram (
  input  logic                                          clk,
  input  rpo_pkg::curve_wr_t                            wr,
  input  logic                                          rd_en,
  input  logic [rpo_pkg::NUM_CH-1:0][rpo_pkg::CURVE_AW-1:0] rd_addr,
  output logic [rpo_pkg::NUM_CH-1:0][rpo_pkg::PIX_W-1:0]    rd_data
);
  import rpo_pkg::*;

  for (genvar g = 0; g < NUM_CH; g++) begin : g_bank
    logic [PIX_W-1:0] mem [CURVE_DEPTH];
    logic [PIX_W-1:0] rd_data_r;

    always_ff @(posedge clk) begin
      if (wr.we) begin
        mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
        rd_data_r <= mem[rd_addr[g]];
      end
    end

    assign rd_data[g] = rd_data_r;
  end

endmodule

// ===== rtl/rgb_pixel_point_ops.sv =====
// RGB pixel point operations: greyscale, invert, power darken and root lighten.
// One pixel per transaction on each channel; the configuration port selects the operation.
// An accepted input transaction passes stage one and then the output register; throughput
// is one pixel per cycle while in_stall and out_stall are low. Stage one reads the curve
// memory at the three channel values, stage two forms the result into the output register.
// Darken and lighten come from a 256-entry curve table that a sequencer rebuilds after
// reset and after every register write; in_stall stays high throughout the rebuild.
// Registers: op_mode at byte address 0, gamma_exponent at byte address 4; pready is
// always high and writes complete in the access cycle.
// Reset is synchronous and active low; it empties the pipeline, restores the register
// defaults and starts a table rebuild.
// When out_stall is high the output register holds its transaction, one more pixel may
// wait in stage one, and in_stall then rises until the output drains.
// Depends on rpo_pkg, rpo_cfg_regs, rpo_curve_gen and rpo_curve_ram.
module rgb_pixel_point_ops #(
  parameter int MAX_EXPONENT = rpo_pkg::MAX_EXPONENT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  rpo_pkg::pixel_in_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output rpo_pkg::pixel_out_t         out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rpo_pkg::CFG_AW-1:0]  paddr,
  input  logic [rpo_pkg::APB_DW-1:0]  pwdata,
  output logic [rpo_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import rpo_pkg::*;

  localparam int NW = $clog2(MAX_EXPONENT + 1);

  cfg_t          cfg;
  logic [NW-1:0] exp_n;
  curve_wr_t     curve_wr;
  logic          gen_busy;

  logic                             in_accept;
  logic [NUM_CH-1:0][CURVE_AW-1:0]  rd_addr;
  logic [NUM_CH-1:0][PIX_W-1:0]     rd_data;

  logic       s1_valid_r;
  pixel_in_t  s1_pix_r;
  logic       out_valid_r;
  pixel_out_t out_data_r;
  pixel_out_t result;
  logic       out_load;

  logic [GREY_SUM_W-1:0]  grey_sum;
  logic [GREY_PROD_W-1:0] grey_prod;
  logic [PIX_W-1:0]       grey_mean;

  rpo_cfg_regs #(.MAX_EXPONENT(MAX_EXPONENT)) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .exp_n   (exp_n)
  );

  rpo_curve_gen #(.MAX_EXPONENT(MAX_EXPONENT)) u_gen (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .exp_n (exp_n),
    .wr    (curve_wr),
    .busy  (gen_busy)
  );

  assign rd_addr[0] = in_data.in_red;
  assign rd_addr[1] = in_data.in_green;
  assign rd_addr[2] = in_data.in_blue;

  rpo_curve_ram u_ram (
    .clk     (clk),
    .wr      (curve_wr),
    .rd_en   (in_accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_load  = !out_valid_r || !out_stall;
  assign in_stall  = gen_busy || (s1_valid_r && !out_load);
  assign in_accept = in_valid && !in_stall;

  assign grey_sum  = GREY_SUM_W'(s1_pix_r.in_red) + GREY_SUM_W'(s1_pix_r.in_green)
                   + GREY_SUM_W'(s1_pix_r.in_blue);
  assign grey_prod = GREY_PROD_W'(grey_sum) * GREY_PROD_W'(GREY_RECIP);
  assign grey_mean = grey_prod[GREY_SHIFT +: PIX_W];

  always_comb begin
    case (cfg.op_mode)
      MODE_GREY: begin
        result.out_red   = grey_mean;
        result.out_green = grey_mean;
        result.out_blue  = grey_mean;
      end
      MODE_INVERT: begin
        result.out_red   = ~s1_pix_r.in_red;
        result.out_green = ~s1_pix_r.in_green;
        result.out_blue  = ~s1_pix_r.in_blue;
      end
      default: begin
        result.out_red   = rd_data[0];
        result.out_green = rd_data[1];
        result.out_blue  = rd_data[2];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (out_load) begin
        s1_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pix_r <= in_data;
    end
    if (out_load && s1_valid_r) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/rpo_checker.sv =====
// Port-level checker for rgb_pixel_point_ops, attached by the bind at the end.
// Checks output holding, pipeline latency and the stall after reset and register writes.
// Depends on rpo_pkg and rgb_pixel_point_ops.
module rpo_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input rpo_pkg::pixel_out_t         out_data,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic                        pready
);
  import rpo_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled output transaction changed or was dropped.");

  a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("Output transaction appeared without an input two cycles earlier.");

  a_stall_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && pready |=> in_stall)
    else $error("Input accepted while the curve table is being rebuilt.");

  a_stall_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> in_stall)
    else $error("Input not stalled at the end of reset.");

endmodule

bind rgb_pixel_point_ops rpo_checker u_rpo_checker (.*);
